FILE: rtl/core/tose_pkg.sv
package tose_pkg;

  // window of past velocities and intervals
  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // average speed limit for the stable flag, compared as a square
  localparam longint unsigned SPEED_LIMIT = 2560;
  localparam logic [47:0] SPEED_LIMIT_SQ = 48'(SPEED_LIMIT * SPEED_LIMIT);

  // interval handling, ms, and the tolerance reset value
  localparam logic [15:0] MAX_GAP        = 16'hFFFF;
  localparam logic [15:0] RESET_INTERVAL = 16'd1000;
  localparam logic [21:0] PERIOD_RESET   = 22'(1000 * WINDOW_DEPTH);
  localparam logic [22:0] TOL_RESET      = 23'd2560;

  // shared arithmetic widths
  localparam int unsigned MUL_W  = 27;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned DVS_W  = 22;
  localparam int unsigned DIV_CW = $clog2(DIV_W);

  localparam logic signed [MUL_W-1:0] MS_PER_S = 27'sd1000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_X,
    CFG_TARGET_Y,
    CFG_TARGET_Z,
    CFG_TARGET_VEL_X,
    CFG_TARGET_VEL_Y,
    CFG_TARGET_VEL_Z,
    CFG_POS_TOL,
    CFG_VEL_TOL
  } tose_cfg_e;

  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               tracked;
    logic               has_meas_velocity;
    logic signed [23:0] meas_vel_x;
    logic signed [23:0] meas_vel_y;
    logic signed [23:0] meas_vel_z;
  } tose_in_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic signed [47:0] integral_x;
    logic signed [47:0] integral_y;
    logic signed [47:0] integral_z;
    logic signed [23:0] avg_vel_x;
    logic signed [23:0] avg_vel_y;
    logic signed [23:0] avg_vel_z;
    logic               stable;
    logic               converged;
  } tose_out_t;

  // clamp to 24 bit signed
  function automatic logic signed [23:0] sat24(input logic signed [48:0] v);
    logic signed [23:0] r;
    if (v > 49'sd8388607) r = 24'sh7FFFFF;
    else if (v < -49'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // clamp to 48 bit signed
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v > 49'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -49'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/tose_mul.sv
module tose_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic signed [tose_pkg::MUL_W-1:0]  a_i,
  input  logic signed [tose_pkg::MUL_W-1:0]  b_i,
  output logic signed [tose_pkg::PROD_W-1:0] p_o
);
  import tose_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // registered signed product, held until the next issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/tose_div.sv
module tose_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tose_pkg::DIV_W-1:0] dividend_i,
  input  logic [tose_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tose_pkg::DIV_W-1:0] quotient_o
);
  import tose_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // one restoring step per cycle, dividend bits shift out as quotient bits shift in
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/tracked_object_state_estimator.sv
// Tracked object state estimator.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one timestamped
// position, optionally with a measured velocity. Output channel
// (out_valid_o/out_ready_i/out_data_o) returns one result per input: velocity,
// integrated position error, window average velocity, stable and converged.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) is
// always ready and writes the target and tolerance registers; write it only
// while no item is in flight.
// The time from transfer to result valid is shortest for a measured velocity
// on an untracked item and longest for a differenced velocity on a tracked
// one. It is set by the shared 48-step restoring divider, run up to six
// times per item (three velocities, three averages); a single registered
// multiplier covers all products. in_ready_o is high only while the sequencer
// is idle, so an item is taken only once the last one has reached S_OUT.
// The result sits in an output register: the next item is taken while it
// waits, and a stalled receiver only holds the sequencer at its final step.
// Reset clears the state, the velocity window to zero, the interval window to
// 1000 ms per entry, targets to zero and tolerances to 2560. No clearing pass.
module tracked_object_state_estimator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tose_pkg::tose_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tose_pkg::tose_out_t  out_data_o
);
  import tose_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_VEL, S_VDIV, S_VWAIT, S_TRK, S_TACC, S_W1, S_W2, S_W3, S_WIN,
    S_ADIV, S_AWAIT, S_SQA, S_SQP, S_SQV, S_SQE, S_TP, S_TV, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic signed [23:0] tgt_pos_q [3];
  logic signed [23:0] tgt_vel_q [3];
  logic [22:0]        pos_tol_q;
  logic [22:0]        vel_tol_q;

  // object state
  tose_in_t           in_q;
  logic [15:0]        dt_q;
  logic [1:0]         axis_q;
  logic signed [23:0] last_pos_q [3];
  logic signed [23:0] cur_vel_q [3];
  logic signed [47:0] integ_q [3];
  logic [31:0]        last_time_q;
  logic signed [23:0] vwin_q [WINDOW_DEPTH][3];
  logic [15:0]        iwin_q [WINDOW_DEPTH];
  logic [WIN_AW-1:0]  wp_q;
  logic signed [47:0] ws_q [3];
  logic [21:0]        psum_q;

  // working registers
  logic signed [23:0] v_q;
  logic signed [47:0] acc_q;
  logic               neg_q;
  logic signed [23:0] avg_q [3];
  logic [47:0]        sp2_q;
  logic [49:0]        pe2_q;
  logic [49:0]        ve2_q;
  logic [45:0]        pt2_q;
  tose_out_t          out_q;
  logic               out_valid_q;

  // shared units
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_q;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;

  // per-axis and derived values
  logic [31:0]              diff_new;
  logic [15:0]              dt_new;
  logic signed [23:0]       pos_a;
  logic signed [23:0]       mv_a;
  logic signed [PROD_W-1:0] mul_mag;
  logic signed [48:0]       ws_ext;
  logic signed [48:0]       ws_mag;
  logic signed [48:0]       quo_s;
  logic signed [PROD_W-1:0] t_rnd;
  logic signed [PROD_W-1:0] term;
  logic signed [48:0]       isum;

  function automatic logic signed [MUL_W-1:0] sx27(input logic [23:0] v);
    return {{(MUL_W-24){v[23]}}, v};
  endfunction

  tose_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_q)
  );

  tose_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // interval: zero counts as 1 ms, long gaps clamp
  assign diff_new = in_data_i.time_ms - last_time_q;
  assign dt_new   = (diff_new == 32'd0) ? 16'd1 :
                    (diff_new > {16'd0, MAX_GAP}) ? MAX_GAP : diff_new[15:0];

  // axis selection of the latched item
  always_comb begin
    unique case (axis_q)
      2'd1:    begin pos_a = in_q.pos_y; mv_a = in_q.meas_vel_y; end
      2'd2:    begin pos_a = in_q.pos_z; mv_a = in_q.meas_vel_z; end
      default: begin pos_a = in_q.pos_x; mv_a = in_q.meas_vel_x; end
    endcase
  end

  // magnitudes and signed quotient around the unsigned divider
  assign mul_mag = mul_q[PROD_W-1] ? -mul_q : mul_q;
  assign ws_ext  = $signed({ws_q[axis_q][47], ws_q[axis_q]});
  assign ws_mag  = ws_q[axis_q][47] ? -ws_ext : ws_ext;
  assign quo_s   = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // trapezoid term, halved toward zero
  assign t_rnd = mul_q + $signed({{(PROD_W-1){1'b0}}, mul_q[PROD_W-1]});
  assign term  = t_rnd >>> 1;
  assign isum  = $signed({integ_q[axis_q][47], integ_q[axis_q]}) + $signed(term[48:0]);

  // operand selection for the shared units
  always_comb begin
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = ws_mag[DIV_W-1:0];
    div_divisor  = psum_q;
    unique case (state_q)
      S_VEL: begin
        mul_en = ~in_q.has_meas_velocity;
        mul_a  = sx27(pos_a) - sx27(last_pos_q[axis_q]);
        mul_b  = MS_PER_S;
      end
      S_VDIV: begin
        div_start    = 1'b1;
        div_dividend = mul_mag[DIV_W-1:0];
        div_divisor  = {{(DVS_W-16){1'b0}}, dt_q};
      end
      S_TRK: begin
        mul_en = in_q.tracked;
        mul_a  = sx27(pos_a) + sx27(last_pos_q[axis_q]) - (sx27(tgt_pos_q[axis_q]) <<< 1);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, dt_q});
      end
      S_W1: begin
        mul_en = 1'b1;
        mul_a  = sx27(v_q);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, dt_q});
      end
      S_W2: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-16){1'b0}}, iwin_q[wp_q]});
        mul_b  = sx27(vwin_q[wp_q][axis_q]);
      end
      S_ADIV: begin
        div_start = 1'b1;
      end
      S_SQA: begin
        mul_en = 1'b1;
        mul_a  = sx27(avg_q[axis_q]);
        mul_b  = sx27(avg_q[axis_q]);
      end
      S_SQP: begin
        mul_en = 1'b1;
        mul_a  = sx27(last_pos_q[axis_q]) - sx27(tgt_pos_q[axis_q]);
        mul_b  = sx27(last_pos_q[axis_q]) - sx27(tgt_pos_q[axis_q]);
      end
      S_SQV: begin
        mul_en = 1'b1;
        mul_a  = sx27(cur_vel_q[axis_q]) - sx27(tgt_vel_q[axis_q]);
        mul_b  = sx27(cur_vel_q[axis_q]) - sx27(tgt_vel_q[axis_q]);
      end
      S_TP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-23){1'b0}}, pos_tol_q});
        mul_b  = $signed({{(MUL_W-23){1'b0}}, pos_tol_q});
      end
      S_TV: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-23){1'b0}}, vel_tol_q});
        mul_b  = $signed({{(MUL_W-23){1'b0}}, vel_tol_q});
      end
      default: begin
      end
    endcase
  end

  // sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        tgt_pos_q[i]  <= '0;
        tgt_vel_q[i]  <= '0;
        last_pos_q[i] <= '0;
        cur_vel_q[i]  <= '0;
        integ_q[i]    <= '0;
        ws_q[i]       <= '0;
        avg_q[i]      <= '0;
      end
      for (int w = 0; w < WINDOW_DEPTH; w++) begin
        iwin_q[w] <= RESET_INTERVAL;
        for (int i = 0; i < 3; i++) begin
          vwin_q[w][i] <= '0;
        end
      end
      pos_tol_q   <= TOL_RESET;
      vel_tol_q   <= TOL_RESET;
      in_q        <= '0;
      dt_q        <= '0;
      axis_q      <= '0;
      last_time_q <= '0;
      wp_q        <= '0;
      psum_q      <= PERIOD_RESET;
      v_q         <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      sp2_q       <= '0;
      pe2_q       <= '0;
      ve2_q       <= '0;
      pt2_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        unique case (tose_cfg_e'(cfg_index_i))
          CFG_TARGET_X:     tgt_pos_q[0] <= cfg_data_i;
          CFG_TARGET_Y:     tgt_pos_q[1] <= cfg_data_i;
          CFG_TARGET_Z:     tgt_pos_q[2] <= cfg_data_i;
          CFG_TARGET_VEL_X: tgt_vel_q[0] <= cfg_data_i;
          CFG_TARGET_VEL_Y: tgt_vel_q[1] <= cfg_data_i;
          CFG_TARGET_VEL_Z: tgt_vel_q[2] <= cfg_data_i;
          CFG_POS_TOL:      pos_tol_q    <= cfg_data_i[22:0];
          CFG_VEL_TOL:      vel_tol_q    <= cfg_data_i[22:0];
        endcase
      end

      // result transfer frees the output register unless a new result loads
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            dt_q    <= dt_new;
            axis_q  <= '0;
            state_q <= S_VEL;
          end
        end
        S_VEL: begin
          if (in_q.has_meas_velocity) begin
            v_q     <= mv_a;
            state_q <= S_TRK;
          end else begin
            state_q <= S_VDIV;
          end
        end
        S_VDIV: begin
          neg_q   <= mul_q[PROD_W-1];
          state_q <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_done) begin
            v_q     <= sat24(quo_s);
            state_q <= S_TRK;
          end
        end
        S_TRK: begin
          state_q <= in_q.tracked ? S_TACC : S_W1;
        end
        S_TACC: begin
          integ_q[axis_q] <= sat48(isum);
          state_q         <= S_W1;
        end
        S_W1: begin
          state_q <= S_W2;
        end
        S_W2: begin
          acc_q   <= ws_q[axis_q] + $signed(mul_q[47:0]);
          state_q <= S_W3;
        end
        S_W3: begin
          ws_q[axis_q]         <= acc_q - $signed(mul_q[47:0]);
          vwin_q[wp_q][axis_q] <= v_q;
          cur_vel_q[axis_q]    <= v_q;
          last_pos_q[axis_q]   <= pos_a;
          if (axis_q == 2'd2) begin
            state_q <= S_WIN;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_VEL;
          end
        end
        S_WIN: begin
          psum_q       <= psum_q + {6'd0, dt_q} - {6'd0, iwin_q[wp_q]};
          iwin_q[wp_q] <= dt_q;
          wp_q         <= (wp_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          last_time_q  <= in_q.time_ms;
          axis_q       <= '0;
          sp2_q        <= '0;
          pe2_q        <= '0;
          ve2_q        <= '0;
          state_q      <= S_ADIV;
        end
        S_ADIV: begin
          neg_q   <= ws_q[axis_q][47];
          state_q <= S_AWAIT;
        end
        S_AWAIT: begin
          if (div_done) begin
            avg_q[axis_q] <= sat24(quo_s);
            state_q       <= S_SQA;
          end
        end
        S_SQA: begin
          state_q <= S_SQP;
        end
        S_SQP: begin
          sp2_q   <= sp2_q + mul_q[47:0];
          state_q <= S_SQV;
        end
        S_SQV: begin
          pe2_q   <= pe2_q + 50'(mul_q[48:0]);
          state_q <= S_SQE;
        end
        S_SQE: begin
          ve2_q <= ve2_q + 50'(mul_q[48:0]);
          if (axis_q == 2'd2) begin
            state_q <= S_TP;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_ADIV;
          end
        end
        S_TP: begin
          state_q <= S_TV;
        end
        S_TV: begin
          pt2_q   <= mul_q[45:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.vel_x      <= cur_vel_q[0];
            out_q.vel_y      <= cur_vel_q[1];
            out_q.vel_z      <= cur_vel_q[2];
            out_q.integral_x <= integ_q[0];
            out_q.integral_y <= integ_q[1];
            out_q.integral_z <= integ_q[2];
            out_q.avg_vel_x  <= avg_q[0];
            out_q.avg_vel_y  <= avg_q[1];
            out_q.avg_vel_z  <= avg_q[2];
            out_q.stable     <= (sp2_q < SPEED_LIMIT_SQ);
            out_q.converged  <= (pe2_q < {4'd0, pt2_q}) &&
                                (ve2_q < {4'd0, mul_q[45:0]});
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // window period sum can never drain to zero
  a_psum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psum_q != '0)
    else $error("period sum reached zero");

  // divider completes only while the sequencer waits for it
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_VWAIT || state_q == S_AWAIT))
    else $error("divider finished outside a wait step");

  // an accepted item starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_VEL))
    else $error("accepted item did not start processing");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_o && !out_ready_i) |=>
      (state_q == S_OUT && $stable(out_data_o)))
    else $error("result register overwritten while stalled");

endmodule
